// ===== design/lbs_pkg.sv =====
// Shared types and constants of the LED blink sequencer.
// No dependencies; every other design file imports this package.
package lbs_pkg;

  localparam int TIME_BITS  = 16;
  localparam int COUNT_BITS = 8;
  localparam int EDGE_BITS  = COUNT_BITS + 1;
  localparam int MAX_CYCLES = 100;
  localparam int MODE_BITS  = 3;
  localparam int PHASE_BITS = 2;

  localparam logic [TIME_BITS-1:0]  TIME_ONES = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONES = '1;
  localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_CYCLES);

  // Request opcodes
  typedef enum logic [MODE_BITS-1:0] {
    MODE_TICK    = 3'd0,
    MODE_EVENT   = 3'd1,
    MODE_ENABLE  = 3'd2,
    MODE_DISABLE = 3'd3,
    MODE_RESET   = 3'd4
  } mode_t;

  // Sequencer phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ON     = 4'b0010,
    PH_OFF    = 4'b0100,
    PH_FINISH = 4'b1000
  } phase_t;

  // Phase codes as reported on the result channel
  localparam logic [PHASE_BITS-1:0] CODE_IDLE   = 2'd0;
  localparam logic [PHASE_BITS-1:0] CODE_ON     = 2'd1;
  localparam logic [PHASE_BITS-1:0] CODE_OFF    = 2'd2;
  localparam logic [PHASE_BITS-1:0] CODE_FINISH = 2'd3;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [TIME_BITS-1:0]  on_time;
    logic [TIME_BITS-1:0]  off_time;
    logic [COUNT_BITS-1:0] cycle_count;
  } item_t;

  typedef struct packed {
    logic                  led_level;
    logic                  event_accepted;
    logic [PHASE_BITS-1:0] phase_now;
  } result_t;

  function automatic logic [PHASE_BITS-1:0] phase_code(input phase_t ph);
    logic [PHASE_BITS-1:0] code;
    unique case (ph)
      PH_IDLE:   code = CODE_IDLE;
      PH_ON:     code = CODE_ON;
      PH_OFF:    code = CODE_OFF;
      PH_FINISH: code = CODE_FINISH;
      default:   code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== design/lbs_if.sv =====
// Valid/ready channel interfaces of the LED blink sequencer.
// Depends on lbs_pkg for field widths.
interface lbs_in_if import lbs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [MODE_BITS-1:0]  mode;
  logic [TIME_BITS-1:0]  on_time;
  logic [TIME_BITS-1:0]  off_time;
  logic [COUNT_BITS-1:0] cycle_count;

  modport source (output valid, mode, on_time, off_time, cycle_count, input ready);
  modport sink   (input valid, mode, on_time, off_time, cycle_count, output ready);
endinterface

interface lbs_out_if import lbs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  led_level;
  logic                  event_accepted;
  logic [PHASE_BITS-1:0] phase_now;

  modport source (output valid, led_level, event_accepted, phase_now, input ready);
  modport sink   (input valid, led_level, event_accepted, phase_now, output ready);
endinterface

// ===== design/lbs_in_stage.sv =====
// Input register of the LED blink sequencer: captures one request.
// Depends on lbs_pkg and lbs_in_if.
module lbs_in_stage import lbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lbs_in_if.sink     in_ch,
  input  logic       advance,
  output logic       s1_valid,
  output item_t      s1_item
);

  logic  valid_r;
  item_t item_r;

  // Take a new request whenever the held one moves on or the stage is empty
  assign in_ch.ready = !valid_r || advance;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= '{mode:        in_ch.mode,
                  on_time:     in_ch.on_time,
                  off_time:    in_ch.off_time,
                  cycle_count: in_ch.cycle_count};
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== design/lbs_seq_core.sv =====
// Sequencer state and its combinational update for one request.
// Depends on lbs_pkg.
module lbs_seq_core import lbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [TIME_BITS-1:0] cfg_wdata,
  input  logic                 fire,
  input  item_t                item,
  output result_t              res
);

  logic [TIME_BITS-1:0] tick_interval_r;
  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] countdown_r, countdown_nxt;
  logic [TIME_BITS-1:0] on_time_r, on_time_nxt;
  logic [TIME_BITS-1:0] off_time_r, off_time_nxt;
  logic [EDGE_BITS-1:0] edges_r, edges_nxt;
  logic                 forever_r, forever_nxt;
  logic                 pending_r, pending_nxt;
  logic                 enabled_r, enabled_nxt;
  logic                 led_r, led_nxt;
  logic                 accepted;
  logic                 remain;
  logic                 count_bad;

  assign remain    = forever_r || (edges_r != '0);
  assign count_bad = (item.cycle_count > MAX_COUNT) && (item.cycle_count != COUNT_ONES);

  // Next state for the request in the input register
  always_comb begin
    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    on_time_nxt   = on_time_r;
    off_time_nxt  = off_time_r;
    edges_nxt     = edges_r;
    forever_nxt   = forever_r;
    pending_nxt   = pending_r;
    enabled_nxt   = enabled_r;
    led_nxt       = led_r;
    accepted      = 1'b0;
    if (fire) begin
      unique case (item.mode)
        MODE_TICK: begin
          if (enabled_r) begin
            unique case (phase_r)
              PH_IDLE: begin
                // Launch the pending event, or drop it if it has nothing to do
                if (pending_r) begin
                  pending_nxt   = 1'b0;
                  countdown_nxt = '0;
                  if ((on_time_r != '0) && remain) begin
                    if (!forever_r) begin
                      edges_nxt = {edges_r[EDGE_BITS-2:0], 1'b0};
                    end
                    countdown_nxt = on_time_r;
                    phase_nxt     = PH_ON;
                  end
                end
              end
              PH_ON: begin
                if ((countdown_r == on_time_r) && !remain) begin
                  phase_nxt = PH_FINISH;
                end else if ((countdown_r == on_time_r) && (on_time_r == TIME_ONES)) begin
                  // Infinite on time: light and stop
                  led_nxt = 1'b1;
                  if (!forever_r) begin
                    edges_nxt = edges_r - 1'b1;
                  end
                  phase_nxt = PH_IDLE;
                end else begin
                  if (countdown_r == on_time_r) begin
                    led_nxt = 1'b1;
                    if (!forever_r) begin
                      edges_nxt = edges_r - 1'b1;
                    end
                  end
                  if (countdown_r >= tick_interval_r) begin
                    countdown_nxt = countdown_r - tick_interval_r;
                  end else begin
                    countdown_nxt = off_time_r;
                    phase_nxt     = PH_OFF;
                  end
                end
              end
              PH_OFF: begin
                if ((countdown_r == off_time_r) && !remain) begin
                  phase_nxt = PH_FINISH;
                end else begin
                  if (countdown_r == off_time_r) begin
                    led_nxt = 1'b0;
                    if (!forever_r) begin
                      edges_nxt = edges_r - 1'b1;
                    end
                  end
                  if (countdown_r >= tick_interval_r) begin
                    countdown_nxt = countdown_r - tick_interval_r;
                  end else begin
                    countdown_nxt = on_time_r;
                    phase_nxt     = PH_ON;
                  end
                end
              end
              PH_FINISH: begin
                led_nxt   = 1'b0;
                phase_nxt = PH_IDLE;
              end
              default: begin
                led_nxt   = 1'b0;
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
        MODE_EVENT: begin
          // Load a blink event unless disabled or the count is out of range
          if (enabled_r && !count_bad) begin
            on_time_nxt  = item.on_time;
            off_time_nxt = item.off_time;
            forever_nxt  = (item.cycle_count == COUNT_ONES);
            edges_nxt    = EDGE_BITS'(item.cycle_count);
            phase_nxt    = PH_IDLE;
            pending_nxt  = 1'b1;
            accepted     = 1'b1;
          end
        end
        MODE_ENABLE:  enabled_nxt = 1'b1;
        MODE_DISABLE: enabled_nxt = 1'b0;
        MODE_RESET: begin
          phase_nxt   = PH_IDLE;
          enabled_nxt = 1'b1;
          pending_nxt = 1'b0;
          led_nxt     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_interval_r <= TIME_BITS'(1);
    end else if (cfg_we) begin
      tick_interval_r <= cfg_wdata;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      countdown_r <= '0;
      on_time_r   <= '0;
      off_time_r  <= '0;
      edges_r     <= '0;
      forever_r   <= 1'b0;
      pending_r   <= 1'b0;
      enabled_r   <= 1'b1;
      led_r       <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      countdown_r <= countdown_nxt;
      on_time_r   <= on_time_nxt;
      off_time_r  <= off_time_nxt;
      edges_r     <= edges_nxt;
      forever_r   <= forever_nxt;
      pending_r   <= pending_nxt;
      enabled_r   <= enabled_nxt;
      led_r       <= led_nxt;
    end
  end

  assign res = '{led_level:      led_nxt,
                 event_accepted: accepted,
                 phase_now:      phase_code(phase_nxt)};

endmodule

// ===== design/lbs_out_stage.sv =====
// Result register of the LED blink sequencer, drives the result channel.
// Depends on lbs_pkg and lbs_out_if.
module lbs_out_stage import lbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s1_valid,
  input  result_t    res,
  output logic       advance,
  lbs_out_if.source  out_ch
);

  logic    valid_r;
  result_t res_r;

  // Move on when the register is empty or its result is being taken
  assign advance = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= s1_valid;
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.led_level      = res_r.led_level;
  assign out_ch.event_accepted = res_r.event_accepted;
  assign out_ch.phase_now      = res_r.phase_now;

endmodule

// ===== design/led_blink_sequencer_unit.sv =====
// LED blink sequencer: one request in, one result out, per item.
// Channels: in_ch takes tick, blink event, enable, disable and reset requests
// with on time, off time and cycle count; out_ch returns the LED level,
// whether a blink event was taken, and the phase after the request.
// cfg_we/cfg_wdata write the tick interval; write it only while idle.
// Path: an accepted request is held in the input register; its result is computed
// combinationally and loaded into the result register, which drives out_ch.
// Throughput: one request per clock unless out_ch stalls; the phase update is
// a single compare, subtract and select between the input and result registers.
// When the receiver stalls, the result register holds and in_ch takes a request
// only if the input register is empty, then deasserts ready.
// Reset (rst_n low, synchronous) empties both registers, sets the phase to
// idle, enables the block, turns the LED off and sets the tick interval to 1.
// Depends on lbs_pkg, lbs_if, lbs_in_stage, lbs_seq_core, lbs_out_stage.
module led_blink_sequencer_unit import lbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lbs_in_if.sink               in_ch,
  lbs_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [TIME_BITS-1:0] cfg_wdata
);

  logic    advance;
  logic    s1_valid;
  item_t   s1_item;
  result_t res;
  logic    fire;

  // Update state as the request leaves the input register
  assign fire = s1_valid && advance;

  lbs_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  lbs_seq_core u_seq_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s1_item),
    .res       (res)
  );

  lbs_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .res      (res),
    .advance  (advance),
    .out_ch   (out_ch)
  );

endmodule

// ===== design/lbs_checker.sv =====
// Port-level checks for led_blink_sequencer_unit, attached by bind.
// Depends on lbs_pkg.
module lbs_checker import lbs_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_led_level,
  input logic                  out_event_accepted,
  input logic [PHASE_BITS-1:0] out_phase_now
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_led_level) && $stable(out_event_accepted)
                                && $stable(out_phase_now))
    else $error("stalled result changed");

  // A taken blink event always leaves the phase idle
  a_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_accepted |-> out_phase_now == CODE_IDLE)
    else $error("accepted event with non-idle phase");

  // An empty result register never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind led_blink_sequencer_unit lbs_checker u_lbs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_led_level      (out_ch.led_level),
  .out_event_accepted (out_ch.event_accepted),
  .out_phase_now      (out_ch.phase_now)
);

// ===== verif/tb_led_blink_sequencer_unit.sv =====
`timescale 1ns / 100ps
// Testbench for led_blink_sequencer_unit: sends blink, tick and control requests
// with random handshake gaps and checks each result against a local predictor.
// Depends on lbs_pkg, lbs_if and the sequencer RTL.
module tb_led_blink_sequencer_unit;
  import lbs_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_REQUESTS  = 1250;
  localparam int SETTING_COUNT    = 6;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED_FIRST = MODE_BITS'(MODE_RESET + 1);
  localparam logic [MODE_BITS-1:0] MODE_UNUSED_LAST  = '1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [TIME_BITS-1:0] cfg_wdata;

  lbs_in_if  in_ch ();
  lbs_out_if out_ch ();

  led_blink_sequencer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted sequencer state
  logic [PHASE_BITS-1:0] seq_phase;
  logic [TIME_BITS-1:0]  countdown_left;
  logic [TIME_BITS-1:0]  on_hold;
  logic [TIME_BITS-1:0]  off_hold;
  logic [TIME_BITS-1:0]  tick_step;
  logic [EDGE_BITS-1:0]  edges_left;
  logic                  repeat_forever;
  logic                  event_pending;
  logic                  seq_enabled;
  logic                  led_lit;

  result_t led_results_due[$];
  result_t due_now;
  int      mismatch_count;
  int      requests_sent;
  bit      no_idle;

  always #5 clk = ~clk;

  function automatic void reset_predictor();
    seq_phase      = CODE_IDLE;
    countdown_left = '0;
    on_hold        = '0;
    off_hold       = '0;
    tick_step      = TIME_BITS'(1);
    edges_left     = '0;
    repeat_forever = 1'b0;
    event_pending  = 1'b0;
    seq_enabled    = 1'b1;
    led_lit        = 1'b0;
  endfunction

  function automatic bit edges_remain();
    return repeat_forever || edges_left != '0;
  endfunction

  function automatic void spend_edge();
    if (!repeat_forever) edges_left = edges_left - 1'b1;
  endfunction

  // Drop the tick step from the countdown, or reload and move on
  function automatic void count_down(logic [TIME_BITS-1:0] reload,
                                     logic [PHASE_BITS-1:0] next_phase);
    if (countdown_left >= tick_step) begin
      countdown_left = countdown_left - tick_step;
    end else begin
      countdown_left = reload;
      seq_phase      = next_phase;
    end
  endfunction

  // Advance the blink phase by one tick
  function automatic void advance_phase();
    case (seq_phase)
      CODE_IDLE: begin
        if (event_pending) begin
          event_pending  = 1'b0;
          countdown_left = '0;
          if (on_hold != '0 && edges_remain()) begin
            if (!repeat_forever) edges_left = edges_left << 1;
            countdown_left = on_hold;
            seq_phase      = CODE_ON;
          end
        end
      end
      CODE_ON: begin
        if (countdown_left == on_hold) begin
          if (!edges_remain()) begin
            seq_phase = CODE_FINISH;
            return;
          end
          led_lit = 1'b1;
          spend_edge();
          // infinite on time: light and stop
          if (on_hold == TIME_ONES) begin
            seq_phase = CODE_IDLE;
            return;
          end
        end
        count_down(off_hold, CODE_OFF);
      end
      CODE_OFF: begin
        if (countdown_left == off_hold) begin
          if (!edges_remain()) begin
            seq_phase = CODE_FINISH;
            return;
          end
          led_lit = 1'b0;
          spend_edge();
        end
        count_down(on_hold, CODE_ON);
      end
      default: begin
        led_lit   = 1'b0;
        seq_phase = CODE_IDLE;
      end
    endcase
  endfunction

  // Apply one request to the predicted state and return the expected result
  function automatic result_t apply_request(item_t rq);
    result_t r;
    logic    took;
    took = 1'b0;
    case (rq.mode)
      MODE_TICK: begin
        if (seq_enabled) advance_phase();
      end
      MODE_EVENT: begin
        if (seq_enabled &&
            !(rq.cycle_count > MAX_COUNT && rq.cycle_count != COUNT_ONES)) begin
          on_hold        = rq.on_time;
          off_hold       = rq.off_time;
          repeat_forever = (rq.cycle_count == COUNT_ONES);
          edges_left     = EDGE_BITS'(rq.cycle_count);
          seq_phase      = CODE_IDLE;
          event_pending  = 1'b1;
          took           = 1'b1;
        end
      end
      MODE_ENABLE:  seq_enabled = 1'b1;
      MODE_DISABLE: seq_enabled = 1'b0;
      MODE_RESET: begin
        seq_phase     = CODE_IDLE;
        seq_enabled   = 1'b1;
        event_pending = 1'b0;
        led_lit       = 1'b0;
      end
      default: ;
    endcase
    r.led_level      = led_lit;
    r.event_accepted = took;
    r.phase_now      = seq_phase;
    return r;
  endfunction

  function automatic item_t make_request(logic [MODE_BITS-1:0] m, logic [TIME_BITS-1:0] on_t,
                                         logic [TIME_BITS-1:0] off_t,
                                         logic [COUNT_BITS-1:0] cyc);
    item_t rq;
    rq.mode        = m;
    rq.on_time     = on_t;
    rq.off_time    = off_t;
    rq.cycle_count = cyc;
    return rq;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one request and record its expected result once accepted
  task automatic send_request(item_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.mode        = rq.mode;
    in_ch.on_time     = rq.on_time;
    in_ch.off_time    = rq.off_time;
    in_ch.cycle_count = rq.cycle_count;
    do @(posedge clk); while (!in_ch.ready);
    led_results_due.push_back(apply_request(rq));
    if (rq.mode <= MODE_RESET) requests_sent++;
  endtask

  task automatic send_noise_request();
    logic [MODE_BITS-1:0] m;
    case ($urandom_range(0, 3))
      0:       m = MODE_ENABLE;
      1:       m = MODE_DISABLE;
      2:       m = MODE_RESET;
      default: m = MODE_BITS'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    endcase
    send_request(make_request(m, TIME_BITS'($urandom), TIME_BITS'($urandom),
                              COUNT_BITS'($urandom)));
  endtask

  // Send ticks with random payload, now and then a control request in between
  task automatic run_ticks(int count, int noise_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise_request();
      else send_request(make_request(MODE_TICK, TIME_BITS'($urandom),
                                     TIME_BITS'($urandom), COUNT_BITS'($urandom)));
    end
  endtask

  task automatic send_event(logic [TIME_BITS-1:0] on_t, logic [TIME_BITS-1:0] off_t,
                            logic [COUNT_BITS-1:0] cyc);
    send_request(make_request(MODE_EVENT, on_t, off_t, cyc));
  endtask

  // Hold off new requests until every result is back and the block is quiet
  task automatic wait_until_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (led_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_tick_step(logic [TIME_BITS-1:0] step);
    wait_until_drained();
    cfg_we    = 1'b1;
    cfg_wdata = step;
    @(negedge clk);
    cfg_we    = 1'b0;
    tick_step = step;
  endtask

  // One finite blink from start to finish
  task automatic test_single_blink();
    send_request(make_request(MODE_TICK, '0, '0, '0));
    send_event(TIME_BITS'(2), TIME_BITS'(1), COUNT_BITS'(1));
    run_ticks(8, 0);
  endtask

  // Counts over the limit, and events or ticks while disabled
  task automatic test_refused_events();
    send_event(TIME_BITS'(3), TIME_BITS'(3), MAX_COUNT + 1'b1);
    send_event(TIME_ONES, TIME_ONES, COUNT_ONES - 1'b1);
    send_request(make_request(MODE_DISABLE, '0, '0, '0));
    run_ticks(1, 0);
    send_event(TIME_BITS'(1), TIME_BITS'(1), COUNT_BITS'(1));
    send_request(make_request(MODE_ENABLE, '0, '0, '0));
  endtask

  // Zero on time, zero count, infinite on time, endless repeat, reset and unused modes
  task automatic test_special_events();
    send_event('0, TIME_BITS'(2), COUNT_BITS'(3));
    run_ticks(1, 0);
    send_event(TIME_BITS'(2), TIME_BITS'(2), '0);
    run_ticks(1, 0);
    send_event(TIME_ONES, TIME_ONES, COUNT_ONES);
    run_ticks(2, 0);
    send_event(TIME_BITS'(1), '0, COUNT_ONES);
    run_ticks(4, 0);
    send_request(make_request(MODE_RESET, TIME_ONES, TIME_ONES, COUNT_ONES));
    for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
      send_request(make_request(MODE_BITS'(m), TIME_ONES, TIME_ONES, COUNT_ONES));
  endtask

  // Zero step: the countdown stalls and each tick repeats the edge
  task automatic test_zero_step();
    set_tick_step('0);
    send_event(TIME_BITS'(1), TIME_BITS'(1), COUNT_BITS'(2));
    run_ticks(7, 0);
  endtask

  function automatic item_t random_blink_event();
    logic [TIME_BITS-1:0]  on_t;
    logic [TIME_BITS-1:0]  off_t;
    logic [COUNT_BITS-1:0] cyc;
    int                    roll;
    roll = $urandom_range(0, 19);
    if (roll == 0)      on_t = TIME_ONES;
    else if (roll == 1) on_t = TIME_BITS'($urandom);
    else                on_t = TIME_BITS'($urandom_range(0, 6));
    roll = $urandom_range(0, 19);
    if (roll < 2) off_t = TIME_BITS'($urandom);
    else          off_t = TIME_BITS'($urandom_range(0, 6));
    roll = $urandom_range(0, 19);
    if (roll < 2)      cyc = COUNT_ONES;
    else if (roll < 4) cyc = COUNT_BITS'($urandom_range(MAX_CYCLES + 1, COUNT_ONES - 1));
    else if (roll < 6) cyc = COUNT_BITS'($urandom_range(5, MAX_CYCLES));
    else               cyc = COUNT_BITS'($urandom_range(0, 4));
    return make_request(MODE_EVENT, on_t, off_t, cyc);
  endfunction

  function automatic int tick_run_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 12);
    if (roll < 95) return $urandom_range(13, 40);
    return $urandom_range(60, 250);
  endfunction

  // Blink events followed by tick runs, with control requests as noise
  task automatic test_random_sequences(logic [TIME_BITS-1:0] step, int quota);
    int target;
    set_tick_step(step);
    target = requests_sent + quota;
    while (requests_sent < target) begin
      if (!seq_enabled && $urandom_range(0, 9) < 7)
        send_request(make_request(MODE_ENABLE, '0, '0, '0));
      if ($urandom_range(0, 4) == 0) begin
        send_noise_request();
      end else begin
        send_request(random_blink_event());
        run_ticks(tick_run_length(), 3);
      end
    end
  endtask

  // Result channel backpressure
  initial begin : result_backpressure
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (led_results_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        due_now = led_results_due.pop_front();
        if (out_ch.led_level !== due_now.led_level) begin
          $error("led_level: expected %0d, got %0d", due_now.led_level, out_ch.led_level);
          mismatch_count++;
        end
        if (out_ch.event_accepted !== due_now.event_accepted) begin
          $error("event_accepted: expected %0d, got %0d",
                 due_now.event_accepted, out_ch.event_accepted);
          mismatch_count++;
        end
        if (out_ch.phase_now !== due_now.phase_now) begin
          $error("phase_now: expected %0d, got %0d", due_now.phase_now, out_ch.phase_now);
          mismatch_count++;
        end
      end
    end
  end

  // Stop the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end while (quiet < WATCHDOG_LIMIT);
    $display("tb_led_blink_sequencer_unit NOT OK");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_TICK;
    in_ch.on_time     = '0;
    in_ch.off_time    = '0;
    in_ch.cycle_count = '0;
    no_idle           = 1'b0;
    mismatch_count    = 0;
    requests_sent     = 0;
    reset_predictor();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_blink();
    test_refused_events();
    test_special_events();
    test_zero_step();

    test_random_sequences(TIME_BITS'(1), RANDOM_REQUESTS / SETTING_COUNT);
    test_random_sequences(TIME_ONES, RANDOM_REQUESTS / SETTING_COUNT);
    test_random_sequences('0, RANDOM_REQUESTS / SETTING_COUNT);
    test_random_sequences(TIME_BITS'(2), RANDOM_REQUESTS / SETTING_COUNT);
    test_random_sequences(TIME_BITS'($urandom_range(3, 20)), RANDOM_REQUESTS / SETTING_COUNT);
    // back to back on both sides
    no_idle = 1'b1;
    test_random_sequences(TIME_BITS'(1), RANDOM_REQUESTS / SETTING_COUNT);
    no_idle = 1'b0;

    wait_until_drained();
    if (mismatch_count == 0 && led_results_due.size() == 0) begin
      $display("tb_led_blink_sequencer_unit OK");
    end else begin
      $display("tb_led_blink_sequencer_unit NOT OK");
    end
    $finish;
  end

endmodule

// ===== led_blink_sequencer_unit.f =====
design/lbs_pkg.sv
design/lbs_if.sv
design/lbs_in_stage.sv
design/lbs_seq_core.sv
design/lbs_out_stage.sv
design/led_blink_sequencer_unit.sv
design/lbs_checker.sv
verif/tb_led_blink_sequencer_unit.sv
